>>> hdl/cte_pkg.sv
`default_nettype none
package cte_pkg;

  localparam int REVOKE_DEPTH = 256;
  localparam int IDX_W = $clog2(REVOKE_DEPTH);
  localparam int FILL_W = IDX_W + 1;
  localparam logic [FILL_W-1:0] DEPTH_CNT = FILL_W'(REVOKE_DEPTH);

  // commands
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_VALIDATE = 2'd1;
  localparam logic [1:0] CMD_REVOKE = 2'd2;
  localparam logic [1:0] CMD_DELEGATE = 2'd3;

  // status codes
  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_ALREADY = 4'd1;
  localparam logic [3:0] ST_NULL = 4'd2;
  localparam logic [3:0] ST_FORGED = 4'd3;
  localparam logic [3:0] ST_REVOKED = 4'd4;
  localparam logic [3:0] ST_RIGHTS = 4'd5;
  localparam logic [3:0] ST_RESOURCE = 4'd6;
  localparam logic [3:0] ST_NULL_TARGET = 4'd7;
  localparam logic [3:0] ST_FULL = 4'd8;

  // config register indexes
  localparam logic [2:0] REG_SECRET0 = 3'd0;
  localparam logic [2:0] REG_SECRET1 = 3'd1;
  localparam logic [2:0] REG_SECRET2 = 3'd2;
  localparam logic [2:0] REG_SECRET3 = 3'd3;
  localparam logic [2:0] REG_KERNEL_KIND = 3'd4;
  localparam logic [2:0] REG_REVOKE_MASK = 3'd5;
  localparam logic [2:0] REG_DELEGATE_MASK = 3'd6;

  localparam logic [31:0] B3_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [3:0] B3_PERM [16] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
  };

  // state word indexes {a,b,c,d} for each of the eight G calls of a round
  localparam logic [15:0] B3_GIDX [8] = '{
    {4'd0, 4'd4, 4'd8, 4'd12}, {4'd1, 4'd5, 4'd9, 4'd13},
    {4'd2, 4'd6, 4'd10, 4'd14}, {4'd3, 4'd7, 4'd11, 4'd15},
    {4'd0, 4'd5, 4'd10, 4'd15}, {4'd1, 4'd6, 4'd11, 4'd12},
    {4'd2, 4'd7, 4'd8, 4'd13}, {4'd3, 4'd4, 4'd9, 4'd14}
  };

endpackage
`default_nettype wire

>>> hdl/cte_if.sv
`default_nettype none
interface cte_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] resource_kind;
  logic [31:0] resource_id;
  logic [63:0] rights;
  logic [31:0] pid;
  logic [31:0] other_pid;
  logic [63:0] token_upper;
  logic [63:0] token_lower;
  logic [63:0] target_upper;
  logic [63:0] target_lower;

  modport source(output valid, command, resource_kind, resource_id, rights, pid, other_pid,
                 token_upper, token_lower, target_upper, target_lower, input ready);
  modport sink(input valid, command, resource_kind, resource_id, rights, pid, other_pid,
               token_upper, token_lower, target_upper, target_lower, output ready);
endinterface

interface cte_rsp_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [3:0]  status;
  logic [63:0] token_out_upper;
  logic [63:0] token_out_lower;

  modport source(output valid, granted, status, token_out_upper, token_out_lower,
                 input ready);
  modport sink(input valid, granted, status, token_out_upper, token_out_lower,
               output ready);
endinterface
`default_nettype wire

>>> hdl/cte_blake.sv
`default_nettype none
module cte_blake import cte_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  upper,
  input  wire logic [31:0]  pid,
  input  wire logic [255:0] secret,
  output logic              done,
  output logic [63:0]       mac
);

  logic [31:0] v [16];
  logic [31:0] m [16];
  logic        busy;
  logic [2:0]  round;
  logic [2:0]  gi;
  logic        half;

  logic [3:0]  ia, ib, ic, id;
  logic [31:0] x, a_n, b_n, c_n, d_n, t_d, t_b;
  logic        last;

  // one half of a G call per cycle
  always_comb begin
    {ia, ib, ic, id} = B3_GIDX[gi];
    x = half ? m[{gi, 1'b1}] : m[{gi, 1'b0}];
    a_n = v[ia] + v[ib] + x;
    t_d = v[id] ^ a_n;
    d_n = half ? {t_d[7:0], t_d[31:8]} : {t_d[15:0], t_d[31:16]};
    c_n = v[ic] + d_n;
    t_b = v[ib] ^ c_n;
    b_n = half ? {t_b[6:0], t_b[31:7]} : {t_b[11:0], t_b[31:12]};
    last = (round == 3'd6) && (gi == 3'd7) && half;
  end

  assign mac = {v[1] ^ v[9], v[0] ^ v[8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      round <= '0;
      gi <= '0;
      half <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        round <= '0;
        gi <= '0;
        half <= 1'b0;
      end else if (busy) begin
        half <= ~half;
        if (half) begin
          gi <= gi + 3'd1;
          if (gi == 3'd7) round <= round + 3'd1;
        end
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int k = 0; k < 8; k++) v[k] <= B3_IV[k];
      for (int k = 0; k < 4; k++) v[8+k] <= B3_IV[k];
      v[12] <= '0;
      v[13] <= '0;
      v[14] <= 32'd44;
      v[15] <= 32'd11; // chunk start, chunk end, root
      m[0] <= upper[31:0];
      m[1] <= upper[63:32];
      m[2] <= pid;
      for (int k = 0; k < 8; k++) m[3+k] <= secret[32*k +: 32];
      for (int k = 11; k < 16; k++) m[k] <= '0;
    end else if (busy) begin
      for (int k = 0; k < 16; k++) begin
        if (4'(k) == ia) v[k] <= a_n;
        if (4'(k) == ib) v[k] <= b_n;
        if (4'(k) == ic) v[k] <= c_n;
        if (4'(k) == id) v[k] <= d_n;
      end
      if (half && gi == 3'd7) begin
        for (int k = 0; k < 16; k++) m[k] <= m[B3_PERM[k]];
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/capability_token_engine.sv
`default_nettype none
// Capability token engine.
// req: one command transaction (create, validate, revoke, delegate) with its
//   operands; accepted when req.valid and req.ready are both high. req.ready
//   is high only while the engine is idle: one command is worked at a time.
// rsp: one result transaction per command (granted, status, produced token),
//   held in an output register until rsp.ready takes it; a stalled receiver
//   simply keeps the engine busy, nothing is lost.
// cfg_*: register writes (secret words, kernel kind, rights masks), taken at
//   any edge with cfg_we high; write only while the engine is idle.
// Work: each MAC is one BLAKE3 compression on a shared G unit, half a G
//   per cycle, 7 rounds x 8 G. A revocation-list search reads the list
//   memory one entry a cycle. Create runs one MAC; validate at most a MAC and
//   a search, delegate two MACs and a search, revoke a MAC and two searches;
//   after the result handoff the engine returns to idle before the next
//   command is taken.
// Reset: registers return to their reset values and the list count goes to
//   zero; list entries at or beyond the count are never compared, so no clearing
//   pass is needed and the engine is ready right after reset.
module capability_token_engine import cte_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  cte_req_if.sink          req,
  cte_rsp_if.source        rsp,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MAC_TOK = 6'b000010,
    S_SCAN    = 6'b000100,
    S_POST    = 6'b001000,
    S_MAC_OUT = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [255:0] secret;
  logic [15:0]  kernel_kind;
  logic [15:0]  revoke_mask;
  logic [15:0]  delegate_mask;

  // latched command
  logic [1:0]  cmd;
  logic [63:0] rights;
  logic [31:0] opid;
  logic [63:0] tu, tl, gu, gl;

  // result
  logic [3:0]  status;
  logic [63:0] ou, ol;

  // MAC unit
  logic        mac_start;
  logic [63:0] mac_upper;
  logic [31:0] mac_pid;
  logic        mac_done;
  logic [63:0] mac;

  // revocation list
  logic [127:0]      mem [REVOKE_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] idx;
  logic [127:0]      rd_data;
  logic              rd_vld;
  logic              scan_tgt;
  logic              hit, scan_end, mem_we;
  logic [127:0]      key;
  logic [63:0]       need;

  cte_blake u_blake (
    .clk(clk), .rst(rst), .start(mac_start), .upper(mac_upper), .pid(mac_pid),
    .secret(secret), .done(mac_done), .mac(mac)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.status = status;
  assign rsp.granted = (status == ST_OK) || (status == ST_ALREADY);
  assign rsp.token_out_upper = ou;
  assign rsp.token_out_lower = ol;

  always_comb begin
    key = scan_tgt ? {gu, gl} : {tu, tl};
    hit = rd_vld && (rd_data == key);
    scan_end = hit || (!rd_vld && idx != '0);
    mem_we = (state == S_SCAN) && scan_tgt && scan_end && !hit && (fill < DEPTH_CNT);
    unique case (cmd)
      CMD_VALIDATE: need = rights;
      CMD_REVOKE:   need = {48'd0, revoke_mask};
      default:      need = {48'd0, delegate_mask};
    endcase
  end

  // list memory: one read, one write port
  always_ff @(posedge clk) begin
    rd_data <= mem[idx[IDX_W-1:0]];
    if (mem_we) mem[fill[IDX_W-1:0]] <= {gu, gl};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      secret <= '0;
      kernel_kind <= '0;
      revoke_mask <= 16'd4;
      delegate_mask <= 16'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SECRET0:       secret[63:0] <= cfg_data;
        REG_SECRET1:       secret[127:64] <= cfg_data;
        REG_SECRET2:       secret[191:128] <= cfg_data;
        REG_SECRET3:       secret[255:192] <= cfg_data;
        REG_KERNEL_KIND:   kernel_kind <= cfg_data[15:0];
        REG_REVOKE_MASK:   revoke_mask <= cfg_data[15:0];
        REG_DELEGATE_MASK: delegate_mask <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      mac_start <= 1'b0;
      rd_vld <= 1'b0;
      idx <= '0;
    end else begin
      mac_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd <= req.command;
            rights <= req.rights;
            opid <= req.other_pid;
            tu <= req.token_upper;
            tl <= req.token_lower;
            gu <= req.target_upper;
            gl <= req.target_lower;
            ol <= '0;
            mac_pid <= req.pid;
            if (req.command == CMD_CREATE) begin
              ou <= {req.resource_kind, req.resource_id, req.rights[15:0]};
              mac_upper <= {req.resource_kind, req.resource_id, req.rights[15:0]};
              mac_start <= 1'b1;
              state <= S_MAC_OUT;
            end else begin
              ou <= '0;
              mac_upper <= req.token_upper;
              if (req.token_upper == '0 && req.token_lower == '0) begin
                status <= ST_NULL;
                state <= S_DONE;
              end else begin
                mac_start <= 1'b1;
                state <= S_MAC_TOK;
              end
            end
          end
        end
        S_MAC_TOK: begin
          if (mac_done) begin
            if (mac != tl) begin
              status <= ST_FORGED;
              state <= S_DONE;
            end else begin
              scan_tgt <= 1'b0;
              idx <= '0;
              rd_vld <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // pipelined search: issue one read, compare the previous one
          rd_vld <= idx < fill;
          idx <= idx + 1'b1;
          if (scan_end) begin
            rd_vld <= 1'b0;
            if (!scan_tgt) begin
              if (hit) begin
                status <= ST_REVOKED;
                state <= S_DONE;
              end else begin
                state <= S_POST;
              end
            end else begin
              state <= S_DONE;
              if (hit) status <= ST_ALREADY;
              else if (fill >= DEPTH_CNT) status <= ST_FULL;
              else begin
                status <= ST_OK;
                fill <= fill + 1'b1;
              end
            end
          end
        end
        S_POST: begin
          if (({48'd0, tu[15:0]} & need) != need) begin
            status <= ST_RIGHTS;
            state <= S_DONE;
          end else begin
            unique case (cmd)
              CMD_REVOKE: begin
                if (tu[63:48] != kernel_kind && tu[63:48] != gu[63:48]) begin
                  status <= ST_RESOURCE;
                  state <= S_DONE;
                end else if (gu == '0 && gl == '0) begin
                  status <= ST_NULL_TARGET;
                  state <= S_DONE;
                end else begin
                  scan_tgt <= 1'b1;
                  idx <= '0;
                  rd_vld <= 1'b0;
                  state <= S_SCAN;
                end
              end
              CMD_DELEGATE: begin
                ou <= {tu[63:16], tu[15:0] & rights[15:0]};
                mac_upper <= {tu[63:16], tu[15:0] & rights[15:0]};
                mac_pid <= opid;
                mac_start <= 1'b1;
                state <= S_MAC_OUT;
              end
              default: begin
                status <= ST_OK;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MAC_OUT: begin
          if (mac_done) begin
            ol <= mac;
            status <= ST_OK;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
